FILE: hw/rtl/fcc_pkg.sv
`default_nettype none

package fcc_pkg;

  // plane register file
  localparam int unsigned NUM_PLANES  = 6;
  localparam int unsigned PLANE_W     = 64;
  localparam int unsigned PLANE_IDX_W = 3;
  localparam int unsigned CFG_IDX_W   = 3;

  // fields
  localparam int unsigned COORD_W = 16;
  localparam int unsigned HALF_W  = 15;
  localparam int unsigned COMP_W  = 16;
  localparam int unsigned ABS_W   = 17;  // sum of three magnitudes
  localparam int unsigned VIS_W   = 2;

  // shared multiply-accumulate unit
  localparam int unsigned OPD_W   = 18;
  localparam int unsigned PROD_W  = 2 * OPD_W;
  localparam int unsigned ACC_W   = 38;
  localparam int unsigned Q_SHIFT = 14;  // Q.4 * Q.14 alignment

  localparam logic [VIS_W-1:0] VIS_OUTSIDE = 2'd0;
  localparam logic [VIS_W-1:0] VIS_PARTIAL = 2'd1;
  localparam logic [VIS_W-1:0] VIS_INSIDE  = 2'd2;

  typedef struct packed {
    logic                    en;
    logic                    first;  // load acc with init instead of adding
    logic signed [OPD_W-1:0] a;
    logic signed [OPD_W-1:0] b;
    logic signed [ACC_W-1:0] init;
  } mac_op_t;

  typedef struct packed {
    logic near_neg;
    logic far_neg;
  } mac_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/frustum_cube_classify_unit.sv
// Channel   Ports                                        Transfer
// ------    -------------------------------------------  --------------------------
// item in   start_i, center_{x,y,z}_i, half_size_i        start_i high, busy_o low
// result    done_o, visibility_o                         every cycle done_o is high
// config    cfg_valid_i, cfg_ready_o, cfg_index_i,       cfg_valid_i & cfg_ready_o
//           cfg_data_i
//
// One plane is stepped through the shared 18x18 multiply-accumulate unit: three
// dot-product terms, the r * sum|n| term, then the near/far compare. busy_o stays high
// while the k visited planes are processed (stops at the first outside plane), and
// done_o pulses in the cycle in which busy_o falls. Reset clears all planes (every node inside).
// The result cannot be held off; a new item may start in the done_o cycle, but not
// while busy_o is high.
`default_nettype none

module frustum_cube_classify_unit #(
  parameter int unsigned PLANE_COUNT = fcc_pkg::NUM_PLANES
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output      logic                                busy_o,
  input  wire logic signed [fcc_pkg::COORD_W-1:0]  center_x_i,
  input  wire logic signed [fcc_pkg::COORD_W-1:0]  center_y_i,
  input  wire logic signed [fcc_pkg::COORD_W-1:0]  center_z_i,
  input  wire logic        [fcc_pkg::HALF_W-1:0]   half_size_i,
  output      logic                                done_o,
  output      logic        [fcc_pkg::VIS_W-1:0]    visibility_o,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic        [fcc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic        [fcc_pkg::PLANE_W-1:0]  cfg_data_i
);
  import fcc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [2:0] STEP_X   = 3'd0;
  localparam logic [2:0] STEP_Y   = 3'd1;
  localparam logic [2:0] STEP_Z   = 3'd2;
  localparam logic [2:0] STEP_R   = 3'd3;
  localparam logic [2:0] STEP_CMP = 3'd4;

  localparam logic [PLANE_IDX_W-1:0] LAST_PLANE = PLANE_IDX_W'(PLANE_COUNT - 1);

  logic [PLANE_W-1:0] planes_q [NUM_PLANES];

  logic                   state_q, state_d;
  logic [2:0]             step_q, step_d;
  logic [PLANE_IDX_W-1:0] plane_q, plane_d;
  logic                   partial_q, partial_d;
  logic                   done_q, done_d;
  logic [VIS_W-1:0]       vis_q, vis_d;

  logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
  logic        [HALF_W-1:0]  r_q;

  logic [PLANE_W-1:0]        plane_sel;
  logic signed [COMP_W-1:0]  nx, ny, nz, dd;
  logic [ABS_W-1:0]          abs_x, abs_y, abs_z, abs_sum;
  logic signed [COMP_W:0]    bias_sum;
  mac_op_t                   mac_op;
  mac_res_t                  mac_res;
  logic                      accept;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q == ST_RUN);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign visibility_o = vis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        planes_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i < CFG_IDX_W'(NUM_PLANES))) begin
      planes_q[PLANE_IDX_W'(cfg_index_i)] <= cfg_data_i;
    end
  end

  assign plane_sel = planes_q[plane_q];
  assign nx = plane_sel[15:0];
  assign ny = plane_sel[31:16];
  assign nz = plane_sel[47:32];
  assign dd = plane_sel[63:48];

  assign abs_x   = nx[COMP_W-1] ? -{nx[COMP_W-1], nx} : {1'b0, nx};
  assign abs_y   = ny[COMP_W-1] ? -{ny[COMP_W-1], ny} : {1'b0, ny};
  assign abs_z   = nz[COMP_W-1] ? -{nz[COMP_W-1], nz} : {1'b0, nz};
  assign abs_sum = abs_x + abs_y + abs_z;

  assign bias_sum = {dd[COMP_W-1], dd} + $signed({2'b00, r_q});

  always_comb begin
    mac_op.en    = (state_q == ST_RUN) && (step_q != STEP_CMP);
    mac_op.first = (step_q == STEP_X);
    mac_op.init  = {{(ACC_W - COMP_W - 1 - Q_SHIFT){bias_sum[COMP_W]}}, bias_sum,
                    {Q_SHIFT{1'b0}}};
    case (step_q)
      STEP_X: begin
        mac_op.a = OPD_W'(nx);
        mac_op.b = OPD_W'(cx_q);
      end
      STEP_Y: begin
        mac_op.a = OPD_W'(ny);
        mac_op.b = OPD_W'(cy_q);
      end
      STEP_Z: begin
        mac_op.a = OPD_W'(nz);
        mac_op.b = OPD_W'(cz_q);
      end
      default: begin
        mac_op.a = $signed({{(OPD_W - ABS_W){1'b0}}, abs_sum});
        mac_op.b = $signed({{(OPD_W - HALF_W){1'b0}}, r_q});
      end
    endcase
  end

  fcc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .res_o  (mac_res)
  );

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    plane_d   = plane_q;
    partial_d = partial_q;
    done_d    = 1'b0;
    vis_d     = vis_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d   = ST_RUN;
          step_d    = STEP_X;
          plane_d   = '0;
          partial_d = 1'b0;
        end
      end
      ST_RUN: begin
        if (step_q != STEP_CMP) begin
          step_d = step_q + 3'd1;
        end else if (mac_res.near_neg) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          vis_d   = VIS_OUTSIDE;
        end else begin
          partial_d = partial_q || mac_res.far_neg;
          if (plane_q == LAST_PLANE) begin
            state_d = ST_IDLE;
            done_d  = 1'b1;
            vis_d   = partial_d ? VIS_PARTIAL : VIS_INSIDE;
          end else begin
            plane_d = plane_q + PLANE_IDX_W'(1);
            step_d  = STEP_X;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= STEP_X;
      plane_q   <= '0;
      partial_q <= 1'b0;
      done_q    <= 1'b0;
      vis_q     <= VIS_INSIDE;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      plane_q   <= plane_d;
      partial_q <= partial_d;
      done_q    <= done_d;
      vis_q     <= vis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      cz_q <= center_z_i;
      r_q  <= half_size_i;
    end
  end

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not start the sequencer");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while still busy");

  a_plane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (plane_q <= LAST_PLANE) && (step_q <= STEP_CMP))
    else $error("plane or step counter out of range");

  a_outside_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && step_q == STEP_CMP && mac_res.near_neg) |=>
      (done_o && visibility_o == VIS_OUTSIDE))
    else $error("outside plane did not end the item");

endmodule

`default_nettype wire

FILE: hw/rtl/fcc_mac.sv
`default_nettype none

module fcc_mac (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire fcc_pkg::mac_op_t op_i,
  output fcc_pkg::mac_res_t    res_o
);
  import fcc_pkg::*;

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  near_sum, far_sum;

  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    prod_d = prod_q;
    acc_d  = acc_q;
    if (op_i.en) begin
      prod_d = op_i.a * op_i.b;
      acc_d  = op_i.first ? op_i.init : acc_q + prod_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
    end
  end

  // acc holds n.c + (d + r) << 14, prod holds r * sum |n|
  assign near_sum = acc_q + prod_ext;
  assign far_sum  = acc_q - prod_ext;

  assign res_o.near_neg = near_sum[ACC_W-1];
  assign res_o.far_neg  = far_sum[ACC_W-1];

endmodule

`default_nettype wire
